// ===== hw/rtl/febm_pkg.sv =====
// febm_pkg: shared types, constants and the extension table of the blocklist matcher
`timescale 1ns / 1ps

package febm_pkg;

  localparam int CharW       = 16;
  localparam int MaxEntryLen = 13;
  localparam int RawW        = MaxEntryLen * 8;
  localparam int EntryLenW   = 4;
  localparam int SlotCount   = 64;
  localparam int SlotW       = 6;
  localparam int QuickEntries = 4;
  localparam int PosW        = 9;

  localparam logic [PosW-1:0]  PosMax   = 9'd511;
  localparam logic [CharW-1:0] DotChar  = 16'h002E;
  localparam logic [CharW-1:0] NulChar  = 16'h0000;
  localparam logic [CharW-1:0] LowerA   = 16'h0061;
  localparam logic [CharW-1:0] LowerZ   = 16'h007A;
  localparam logic [CharW-1:0] CaseDiff = 16'h0020;

  // one table row, first character in the top byte
  typedef struct packed {
    logic [EntryLenW-1:0] len;
    logic [RawW-1:0]      chars;
  } entry_t;

  typedef struct packed {
    logic accept_char;
    logic scan_next;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic at_end;
  } dp_status_t;

  function automatic logic [CharW-1:0] fold_upper(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= LowerA && c <= LowerZ) begin
      r = c - CaseDiff;
    end
    return r;
  endfunction

  // entries are stored already folded to upper case, in hex bytes
  function automatic entry_t entry_lookup(input logic [SlotW-1:0] slot);
    logic [RawW-1:0] raw;
    entry_t          e;
    case (slot)
      6'd0:  raw = 104'h2E4352595054;
      6'd1:  raw = 104'h2E4C4F434B4544;
      6'd2:  raw = 104'h2E454E43525950544544;
      6'd3:  raw = 104'h2E52414E534F4D;
      6'd4:  raw = 104'h2E43525950544F;
      6'd5:  raw = 104'h2E5854424C;
      6'd6:  raw = 104'h2E5A4550544F;
      6'd7:  raw = 104'h2E434552424552;
      6'd8:  raw = 104'h2E4C4F434B424954;
      6'd9:  raw = 104'h2E4C4F434B42495432;
      6'd10: raw = 104'h2E4C4F434B42495433;
      6'd11: raw = 104'h2E4C42;
      6'd12: raw = 104'h2E4142524148414D;
      6'd13: raw = 104'h2E434F4E5449;
      6'd14: raw = 104'h2E434F4E5459;
      6'd15: raw = 104'h2E434F4E54494352595054;
      6'd16: raw = 104'h2E414B495241;
      6'd17: raw = 104'h2E414B52;
      6'd18: raw = 104'h2E5259554B;
      6'd19: raw = 104'h2E52594B;
      6'd20: raw = 104'h2E50484F424F53;
      6'd21: raw = 104'h2E50484F;
      6'd22: raw = 104'h2E4445564F53;
      6'd23: raw = 104'h2E454C424945;
      6'd24: raw = 104'h2E424C41434B434154;
      6'd25: raw = 104'h2E414C504856;
      6'd26: raw = 104'h2E524F59414C;
      6'd27: raw = 104'h2E524F59414C34;
      6'd28: raw = 104'h2E434C4F50;
      6'd29: raw = 104'h2E434C3050;
      6'd30: raw = 104'h2E48495645;
      6'd31: raw = 104'h2E4249414E4C49414E;
      6'd32: raw = 104'h2E574E435259;
      6'd33: raw = 104'h2E574E5259;
      6'd34: raw = 104'h2E57435259;
      6'd35: raw = 104'h2E43525950544F4C4F434B4552;
      6'd36: raw = 104'h2E43525950544F57414C4C;
      6'd37: raw = 104'h2E5445534C414352595054;
      6'd38: raw = 104'h2E4C4F434B59;
      6'd39: raw = 104'h2E53414745;
      6'd40: raw = 104'h2E53504F5241;
      6'd41: raw = 104'h2E474C4F4245;
      6'd42: raw = 104'h2E5055524745;
      6'd43: raw = 104'h2E435259534953;
      6'd44: raw = 104'h2E4152454E41;
      6'd45: raw = 104'h2E444A5655;
      6'd46: raw = 104'h2E53544F50;
      6'd47: raw = 104'h2E50554D41;
      6'd48: raw = 104'h2E534841444F57;
      6'd49: raw = 104'h2E4441524B4E455353;
      default: raw = '0;
    endcase
    e.len = '0;
    for (int i = 0; i < MaxEntryLen; i++) begin
      if (raw[8*i +: 8] != 8'h00) begin
        e.len = EntryLenW'(i + 1);
      end
    end
    e.chars = raw << (8 * (MaxEntryLen - int'(e.len)));
    return e;
  endfunction

endpackage

// ===== hw/rtl/febm_ctrl.sv =====
// febm_ctrl: sequencer for character intake, table scan and result hand-off
`timescale 1ns / 1ps

module febm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 last_char_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output febm_pkg::dp_cmd_t    cmd_o,
  input  febm_pkg::dp_status_t status_i
);
  import febm_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic scan_done;

  assign scan_done = status_i.hit | status_i.at_end;

  always_comb begin
    state_d           = state_q;
    cmd_o.accept_char = 1'b0;
    cmd_o.scan_next   = 1'b0;
    cmd_o.load_out    = 1'b0;
    in_ready_o        = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o        = 1'b1;
        cmd_o.accept_char = in_valid_i;
        if (in_valid_i && last_char_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_done) begin
          // wait here while the previous result is still held
          if (!out_valid_q || out_ready_i) begin
            cmd_o.load_out = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/febm_dp.sv =====
// febm_dp: extension capture registers, table compare and result registers
`timescale 1ns / 1ps

module febm_dp #(
  parameter int EXT_CHARS     = 16,
  parameter int FULL_WINDOW   = 256,
  parameter int QUICK_WINDOW  = 64,
  parameter int TABLE_ENTRIES = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [febm_pkg::CharW-1:0]    name_char_i,
  input  febm_pkg::dp_cmd_t             cmd_i,
  output febm_pkg::dp_status_t          status_o,
  output logic                          matched_o,
  output logic [febm_pkg::SlotW-1:0]    entry_index_o,
  output logic                          dot_found_o
);
  import febm_pkg::*;

  localparam int LenW = $clog2(EXT_CHARS + 1);
  localparam int IdxW = $clog2(EXT_CHARS);
  localparam int Limit = (TABLE_ENTRIES > SlotCount) ? SlotCount : TABLE_ENTRIES;
  localparam int QuickLimit = (Limit > QuickEntries) ? QuickEntries : Limit;
  localparam logic [PosW-1:0]  FullWin   = PosW'(FULL_WINDOW);
  localparam logic [PosW-1:0]  QuickWin  = PosW'(QUICK_WINDOW);
  localparam logic [SlotW-1:0] FullLast  = SlotW'(Limit - 1);
  localparam logic [SlotW-1:0] QuickLast = SlotW'(QuickLimit - 1);
  localparam logic [LenW-1:0]  ExtMax    = LenW'(EXT_CHARS);

  logic                  quick_q;
  logic [CharW-1:0]      ext_q [EXT_CHARS];
  logic [LenW-1:0]       len_q;
  logic                  too_long_q;
  logic                  dot_q;
  logic [PosW-1:0]       pos_q;
  logic                  nul_q;
  logic [SlotW-1:0]      slot_q;

  logic [PosW-1:0]       window;
  logic [SlotW-1:0]      last_slot;
  logic                  is_dot;
  logic                  ext_room;
  entry_t                entry;
  logic                  entry_eq;

  assign window    = quick_q ? QuickWin : FullWin;
  assign last_slot = quick_q ? QuickLast : FullLast;
  assign is_dot    = (name_char_i == DotChar) && (pos_q < window);
  assign ext_room  = len_q < ExtMax;

  // compare the captured extension against the current table row
  always_comb begin
    entry    = entry_lookup(slot_q);
    entry_eq = (entry.len != '0) && !too_long_q && (len_q == LenW'(entry.len));
    for (int i = 0; i < MaxEntryLen; i++) begin
      if (i < int'(entry.len)) begin
        if (fold_upper(ext_q[i]) != {8'h00, entry.chars[RawW-1-8*i -: 8]}) begin
          entry_eq = 1'b0;
        end
      end
    end
  end

  assign status_o.hit    = dot_q && entry_eq;
  assign status_o.at_end = !dot_q || (slot_q == last_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quick_q <= 1'b0;
    end else if (cfg_we_i) begin
      quick_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      too_long_q <= 1'b0;
      dot_q      <= 1'b0;
      pos_q      <= '0;
      nul_q      <= 1'b0;
      slot_q     <= '0;
    end else if (cmd_i.load_out) begin
      len_q      <= '0;
      too_long_q <= 1'b0;
      dot_q      <= 1'b0;
      pos_q      <= '0;
      nul_q      <= 1'b0;
      slot_q     <= '0;
    end else begin
      if (cmd_i.scan_next) begin
        slot_q <= slot_q + SlotW'(1);
      end
      if (cmd_i.accept_char) begin
        if (!nul_q) begin
          if (name_char_i == NulChar) begin
            nul_q <= 1'b1;
          end else if (is_dot) begin
            dot_q      <= 1'b1;
            len_q      <= LenW'(1);
            too_long_q <= 1'b0;
          end else if (dot_q) begin
            if (ext_room) begin
              len_q <= len_q + LenW'(1);
            end else begin
              too_long_q <= 1'b1;
            end
          end
        end
        if (pos_q != PosMax) begin
          pos_q <= pos_q + PosW'(1);
        end
      end
    end
  end

  // extension characters, only positions below the length are ever compared
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_char && !nul_q && name_char_i != NulChar) begin
      if (is_dot) begin
        ext_q[0] <= name_char_i;
      end else if (dot_q && ext_room) begin
        ext_q[len_q[IdxW-1:0]] <= name_char_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      matched_o     <= status_o.hit;
      entry_index_o <= status_o.hit ? slot_q : '0;
      dot_found_o   <= dot_q;
    end
  end

endmodule

// ===== hw/rtl/file_extension_blocklist_match.sv =====
// file_extension_blocklist_match: top level of the blocklisted extension matcher
`timescale 1ns / 1ps

// Takes a file name as UTF-16 code units and, on the item marked last,
// reports whether the extension (last dot in the search window up to a NUL
// or the end) equals one of a fixed table of blocklisted extensions, letters
// a..z compared case-insensitively. Characters are accepted one per cycle
// while the sequencer is idle; in_ready_o is low while the table is walked
// and while a finished result waits for the previous one to be taken. After
// the last character the table is walked one entry per cycle by a single
// compare unit, stopping at the first hit or the last entry (one entry when no
// dot was seen, at most TABLE_ENTRIES capped at 64, or at most 4 in quick
// mode). The result sits in an output register, so the next name's characters
// are taken while it waits. quick_mode is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while idle, the block itself does not enforce it.
module file_extension_blocklist_match #(
  parameter int EXT_CHARS     = 16,
  parameter int FULL_WINDOW   = 256,
  parameter int QUICK_WINDOW  = 64,
  parameter int TABLE_ENTRIES = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [febm_pkg::CharW-1:0]    name_char_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [febm_pkg::SlotW-1:0]    entry_index_o,
  output logic                          dot_found_o
);
  import febm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  febm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  febm_dp #(
    .EXT_CHARS     (EXT_CHARS),
    .FULL_WINDOW   (FULL_WINDOW),
    .QUICK_WINDOW  (QUICK_WINDOW),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .name_char_i   (name_char_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .matched_o     (matched_o),
    .entry_index_o (entry_index_o),
    .dot_found_o   (dot_found_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the blocklisted file extension matcher
`timescale 1ns / 1ps

package febm_tb_pkg;

  typedef logic [febm_pkg::CharW-1:0] uchar_t;

  localparam int NumBlocked   = 50;
  localparam int QuickCount   = 4;
  localparam int ExtSlots     = 16;
  localparam int FullWin      = 256;
  localparam int QuickWin     = 64;
  localparam int PosLimit     = 511;
  localparam int EntryBytes   = 13;

  // upper-case ascii, dot first, right-justified
  localparam logic [8*EntryBytes-1:0] BLOCKED_EXT [NumBlocked] = '{
    104'h2E4352595054, 104'h2E4C4F434B4544, 104'h2E454E43525950544544,
    104'h2E52414E534F4D, 104'h2E43525950544F, 104'h2E5854424C,
    104'h2E5A4550544F, 104'h2E434552424552, 104'h2E4C4F434B424954,
    104'h2E4C4F434B42495432, 104'h2E4C4F434B42495433, 104'h2E4C42,
    104'h2E4142524148414D, 104'h2E434F4E5449, 104'h2E434F4E5459,
    104'h2E434F4E54494352595054, 104'h2E414B495241, 104'h2E414B52,
    104'h2E5259554B, 104'h2E52594B, 104'h2E50484F424F53,
    104'h2E50484F, 104'h2E4445564F53, 104'h2E454C424945,
    104'h2E424C41434B434154, 104'h2E414C504856, 104'h2E524F59414C,
    104'h2E524F59414C34, 104'h2E434C4F50, 104'h2E434C3050,
    104'h2E48495645, 104'h2E4249414E4C49414E, 104'h2E574E435259,
    104'h2E574E5259, 104'h2E57435259, 104'h2E43525950544F4C4F434B4552,
    104'h2E43525950544F57414C4C, 104'h2E5445534C414352595054, 104'h2E4C4F434B59,
    104'h2E53414745, 104'h2E53504F5241, 104'h2E474C4F4245,
    104'h2E5055524745, 104'h2E435259534953, 104'h2E4152454E41,
    104'h2E444A5655, 104'h2E53544F50, 104'h2E50554D41,
    104'h2E534841444F57, 104'h2E4441524B4E455353
  };

  function automatic int blocked_len(int slot);
    int n;
    n = 0;
    for (int i = 0; i < EntryBytes; i++) begin
      if (BLOCKED_EXT[slot][8*i +: 8] != 8'h00) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic uchar_t blocked_char(int slot, int pos);
    int n;
    n = blocked_len(slot);
    return {8'h00, BLOCKED_EXT[slot][8*(n-1-pos) +: 8]};
  endfunction

  function automatic uchar_t to_upper(uchar_t c);
    if (c >= febm_pkg::LowerA && c <= febm_pkg::LowerZ) begin
      return c - febm_pkg::CaseDiff;
    end
    return c;
  endfunction

  typedef struct packed {
    logic                        matched;
    logic [febm_pkg::SlotW-1:0]  entry_index;
    logic                        dot_found;
  } verdict_t;

  class ext_scoreboard;
    verdict_t expected_q[$];
    int       fail_count;
    int       checked_count;
    uchar_t   ext_buf [ExtSlots];
    int       ext_len;
    bit       ext_overflow;
    bit       saw_dot;
    bit       saw_nul;
    bit       quick;
    int       pos;

    function new();
      fail_count    = 0;
      checked_count = 0;
      quick         = 1'b0;
      restart();
    endfunction

    function void restart();
      foreach (ext_buf[i]) ext_buf[i] = '0;
      ext_len      = 0;
      ext_overflow = 1'b0;
      saw_dot      = 1'b0;
      saw_nul      = 1'b0;
      pos          = 0;
    endfunction

    function void set_quick(bit q);
      quick = q;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit ext_equals(int slot);
      int n;
      n = blocked_len(slot);
      if (n == 0 || ext_overflow || n != ext_len) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (to_upper(ext_buf[i]) != to_upper(blocked_char(slot, i))) return 1'b0;
      end
      return 1'b1;
    endfunction

    // track one accepted character, queue a verdict on the last one
    function void note_char(uchar_t c, logic last);
      int       window;
      int       limit;
      verdict_t v;
      window = quick ? QuickWin : FullWin;
      if (!saw_nul) begin
        if (c == febm_pkg::NulChar) begin
          saw_nul = 1'b1;
        end else if (c == febm_pkg::DotChar && pos < window) begin
          saw_dot      = 1'b1;
          ext_buf[0]   = c;
          ext_len      = 1;
          ext_overflow = 1'b0;
        end else if (saw_dot) begin
          if (ext_len < ExtSlots) begin
            ext_buf[ext_len] = c;
            ext_len++;
          end else begin
            ext_overflow = 1'b1;
          end
        end
      end
      if (pos < PosLimit) pos++;
      if (!last) return;
      limit         = quick ? QuickCount : NumBlocked;
      v.matched     = 1'b0;
      v.entry_index = '0;
      v.dot_found   = saw_dot;
      if (saw_dot) begin
        for (int s = 0; s < limit && !v.matched; s++) begin
          if (ext_equals(s)) begin
            v.matched     = 1'b1;
            v.entry_index = febm_pkg::SlotW'(s);
          end
        end
      end
      expected_q.push_back(v);
      restart();
    endfunction

    function void check_verdict(logic m, logic [febm_pkg::SlotW-1:0] idx, logic d);
      verdict_t want;
      checked_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result matched=%0d entry=%0d dot=%0d", $time, m, idx, d);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (m !== want.matched) begin
        $display("%0t: matched expected %0d got %0d", $time, want.matched, m);
        fail_count++;
      end
      if (idx !== want.entry_index) begin
        $display("%0t: entry_index expected %0d got %0d", $time, want.entry_index, idx);
        fail_count++;
      end
      if (d !== want.dot_found) begin
        $display("%0t: dot_found expected %0d got %0d", $time, want.dot_found, d);
        fail_count++;
      end
    endfunction
  endclass

endpackage

module tb_top;
  import febm_tb_pkg::*;

  localparam int SettleCycles  = 60;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 750;
  localparam int NumPhases     = 6;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic                         cfg_wdata;
  logic                         in_valid;
  logic                         in_ready_o;
  uchar_t                       name_char;
  logic                         last_char;
  logic                         out_valid_o;
  logic                         out_ready;
  logic                         matched_o;
  logic [febm_pkg::SlotW-1:0]   entry_index_o;
  logic                         dot_found_o;

  ext_scoreboard board;
  bit            in_gaps_on;
  bit            out_stalls_on;
  int            chars_sent;
  uchar_t        name_q[$];

  always #1 clk = ~clk;

  file_extension_blocklist_match dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .name_char_i   (name_char),
    .last_char_i   (last_char),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .matched_o     (matched_o),
    .entry_index_o (entry_index_o),
    .dot_found_o   (dot_found_o)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic uchar_t plain_char();
    int     r;
    uchar_t c;
    r = $urandom_range(0, 9);
    if (r < 5) return uchar_t'($urandom_range(16'h61, 16'h7A));
    if (r < 7) return uchar_t'($urandom_range(16'h41, 16'h5A));
    if (r < 8) return uchar_t'($urandom_range(16'h30, 16'h39));
    c = uchar_t'($urandom);
    if (c == febm_pkg::NulChar || c == febm_pkg::DotChar) c = 16'h005F;
    return c;
  endfunction

  function automatic uchar_t shuffle_case(uchar_t c);
    if (c >= 16'h41 && c <= 16'h5A && $urandom_range(0, 1) == 1) return c + febm_pkg::CaseDiff;
    return c;
  endfunction

  function automatic void add_stem(ref uchar_t q[$], input int n);
    repeat (n) q.push_back(plain_char());
  endfunction

  function automatic void add_entry(ref uchar_t q[$], input int slot);
    for (int i = 0; i < blocked_len(slot); i++) q.push_back(shuffle_case(blocked_char(slot, i)));
  endfunction

  function automatic int pick_slot();
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, QuickCount - 1);
    return $urandom_range(0, NumBlocked - 1);
  endfunction

  function automatic void make_name(ref uchar_t q[$]);
    int r;
    int slot;
    int base;
    int k;
    q.delete();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      add_stem(q, $urandom_range(0, 6));
      add_entry(q, pick_slot());
    end else if (r < 50) begin
      // near miss of a table entry
      add_stem(q, $urandom_range(0, 4));
      slot = pick_slot();
      base = q.size();
      add_entry(q, slot);
      k = base + $urandom_range(1, blocked_len(slot) - 1);
      case ($urandom_range(0, 4))
        0: void'(q.pop_back());
        1: q.push_back(plain_char());
        2: q[k] = q[k] ^ 16'h0100;
        3: q[k] = q[k] ^ 16'h0040;
        default: q[k] = $urandom_range(0, 1) ? 16'h0060 : 16'h007B;
      endcase
    end else if (r < 60) begin
      // nul cuts the name short, the rest is ignored
      add_stem(q, $urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) q.push_back(febm_pkg::NulChar);
      add_entry(q, pick_slot());
      if ($urandom_range(0, 1) == 1) void'(q.pop_back());
      q.push_back(febm_pkg::NulChar);
      repeat ($urandom_range(0, 5)) begin
        q.push_back($urandom_range(0, 2) == 0 ? febm_pkg::DotChar : uchar_t'($urandom));
      end
    end else if (r < 68) begin
      // extension near and past the stored length
      if ($urandom_range(0, 1) == 1) begin
        add_entry(q, 35);
        add_stem(q, $urandom_range(1, 5));
      end else begin
        q.push_back(febm_pkg::DotChar);
        add_stem(q, $urandom_range(12, 20));
      end
    end else if (r < 78) begin
      add_stem(q, $urandom_range(0, 4));
      q.push_back(febm_pkg::DotChar);
      add_stem(q, $urandom_range(0, 4));
      if ($urandom_range(0, 1) == 1) begin
        add_entry(q, pick_slot());
        if ($urandom_range(0, 1) == 1) begin
          q.push_back(febm_pkg::DotChar);
          add_stem(q, $urandom_range(1, 3));
        end
      end else begin
        q.push_back(febm_pkg::DotChar);
        add_stem(q, $urandom_range(0, 4));
      end
    end else if (r < 88) begin
      repeat ($urandom_range(1, 12)) begin
        k = $urandom_range(0, 15);
        if (k < 4) q.push_back(febm_pkg::DotChar);
        else if (k == 4) q.push_back(febm_pkg::NulChar);
        else q.push_back(uchar_t'($urandom));
      end
    end else if (r < 93) begin
      add_stem(q, $urandom_range(1, 10));
    end else if (r < 99) begin
      // dot around the quick window edge
      if ($urandom_range(0, 1) == 1) begin
        q.push_back(febm_pkg::DotChar);
        add_stem(q, 2);
      end
      add_stem(q, $urandom_range(56, 70) - q.size());
      add_entry(q, pick_slot());
    end else begin
      // dot around the full window edge
      if ($urandom_range(0, 1) == 1) add_entry(q, pick_slot());
      add_stem(q, $urandom_range(250, 262) - q.size());
      add_entry(q, pick_slot());
    end
  endfunction

  task automatic send_char(input uchar_t c, input logic last);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    name_char <= c;
    last_char <= last;
    do @(posedge clk); while (!in_ready_o);
    board.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_span(input uchar_t q[$], input int lo, input int hi);
    for (int i = lo; i < hi; i++) send_char(q[i], i == q.size() - 1);
  endtask

  // drop valid, wait for every verdict, then let the table walk finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input bit q);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_quick(q);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      board.check_verdict(matched_o, entry_index_o, dot_found_o);
    end
  end

  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL file_extension_blocklist_match");
    $finish;
  end

  initial begin
    int cut;
    int target;
    bit next_mode;
    board         = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    name_char     = '0;
    last_char     = 1'b0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    chars_sent    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    // lone dot, no dot, lone nul, all-ones character
    name_q = '{febm_pkg::DotChar};
    send_span(name_q, 0, name_q.size());
    name_q = '{16'h0051};
    send_span(name_q, 0, name_q.size());
    name_q = '{febm_pkg::NulChar};
    send_span(name_q, 0, name_q.size());
    name_q = '{16'hFFFF};
    send_span(name_q, 0, name_q.size());
    // mixed case hit and the last table entry
    name_q = '{febm_pkg::DotChar, 16'h006C, 16'h0042};
    send_span(name_q, 0, name_q.size());
    name_q.delete();
    add_entry(name_q, NumBlocked - 1);
    send_span(name_q, 0, name_q.size());
    // characters after a nul do not extend the extension
    name_q = '{febm_pkg::DotChar, 16'h006C, febm_pkg::NulChar, 16'h0062};
    send_span(name_q, 0, name_q.size());
    // switch to quick mode in mid-name: entry past the first four no longer hits
    name_q.delete();
    add_entry(name_q, 6);
    send_span(name_q, 0, 4);
    settle();
    write_mode(1'b1);
    send_span(name_q, 4, name_q.size());
    settle();
    write_mode(1'b0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      in_gaps_on    = !(ph == 0 || ph == 3);
      out_stalls_on = (ph != 0);
      target        = chars_sent + RandomItems / NumPhases;
      while (chars_sent < target) begin
        make_name(name_q);
        send_span(name_q, 0, name_q.size());
      end
      // phase boundary, often in the middle of a name
      make_name(name_q);
      cut = (name_q.size() > 1 && $urandom_range(0, 1) == 1) ?
            $urandom_range(1, name_q.size() - 1) : 0;
      send_span(name_q, 0, cut);
      settle();
      next_mode = (ph % 2 == 0);
      write_mode(next_mode);
      send_span(name_q, cut, name_q.size());
    end

    settle();
    if (board.pending() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, board.pending());
    end
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("PASS file_extension_blocklist_match");
    end else begin
      $display("FAIL file_extension_blocklist_match");
    end
    $finish;
  end

endmodule
